FILE: hw/rtl/green_gauss_scalar_gradient_top_assert.svh
// assertion macros for the green-gauss gradient block
// used by green_gauss_scalar_gradient_top; expects clk and rst_n in scope
`ifndef GREEN_GAUSS_SCALAR_GRADIENT_TOP_ASSERT_SVH
`define GREEN_GAUSS_SCALAR_GRADIENT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GGSG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define GGSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ggsg_pkg.sv
// shared types and constants of the green-gauss gradient block
// no dependencies
package ggsg_pkg;

  localparam int CELL_W = 10;
  localparam int VAL_W  = 32;
  localparam int VOL_W  = 31;
  localparam int ACC_W  = 48;
  // widest face flux, reached at the smallest fraction width
  localparam int FLUX_W = 57;

  typedef enum logic [1:0] {
    REQ_INTERNAL  = 2'd0,
    REQ_BOUNDARY  = 2'd1,
    REQ_PROCESSOR = 2'd2,
    REQ_FINALIZE  = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t                 kind;
    logic [CELL_W-1:0]         own;
    logic [CELL_W-1:0]         nei;
    logic signed [FLUX_W-1:0]  fx;
    logic signed [FLUX_W-1:0]  fy;
    logic signed [FLUX_W-1:0]  fz;
    logic signed [VAL_W-1:0]   scale;
    logic [VOL_W-1:0]          vol;
  } op_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL_A, F_MUL_B, F_FX, F_FY, F_FZ, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ORD, B_OWR, B_NRD, B_NWR, B_FRD, B_FLD,
    B_MLO, B_MHI, B_CHK, B_DIV, B_RND, B_EMIT
  } back_state_t;

endpackage

FILE: hw/rtl/ggsg_front.sv
// front end: takes a beat; for faces forms face value, then x, y and z flux on one shared multiplier
// depends on ggsg_pkg
module ggsg_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    in_req_type,
  input  logic [ggsg_pkg::CELL_W-1:0]   in_owner_cell,
  input  logic [ggsg_pkg::CELL_W-1:0]   in_neighbour_cell,
  input  logic signed [31:0]            in_normal_x,
  input  logic signed [31:0]            in_normal_y,
  input  logic signed [31:0]            in_normal_z,
  input  logic [16:0]                   in_weight,
  input  logic signed [31:0]            in_value_owner,
  input  logic signed [31:0]            in_value_other,
  input  logic signed [31:0]            in_cell_scale,
  input  logic [30:0]                   in_cell_volume,
  input  logic                          q_full,
  output logic                          front_busy,
  output logic                          push,
  output ggsg_pkg::op_t                 push_op
);

  localparam int WW = (FRACTION_BITS + 1 > 17) ? FRACTION_BITS + 1 : 17;
  localparam int PW = WW + 33;
  localparam logic [WW-1:0] ONE_W = WW'(1) << FRACTION_BITS;
  localparam logic signed [PW:0] HALF_P = (PW+1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [64:0] HALF_F = 65'(1) << (FRACTION_BITS - 1);

  ggsg_pkg::front_state_t state_r, state_nxt;
  ggsg_pkg::req_kind_t kind_r;
  logic [ggsg_pkg::CELL_W-1:0] own_r, nei_r;
  logic signed [31:0] nx_r, ny_r, nz_r, vo_r, vx_r, scale_r, phi_r;
  logic [30:0] vol_r;
  logic [WW-1:0] w_r, w_ext, w_cl;
  logic signed [PW-1:0] pa_r, pa_nxt, pb;
  logic signed [PW:0] sum, sum_sh;
  logic signed [ggsg_pkg::FLUX_W-1:0] fx_r, fy_r, fz_r;
  logic signed [31:0] nsel, msel;
  logic signed [64:0] fp, fp_sh;
  logic signed [WW:0] ws, wo;

  assign w_ext = WW'(in_weight);
  assign w_cl  = (w_ext > ONE_W) ? ONE_W : w_ext;

  always_comb begin
    ws = $signed({1'b0, w_r});
    wo = $signed({1'b0, ONE_W - w_r});
    msel = (kind_r == ggsg_pkg::REQ_BOUNDARY) ? vx_r : vo_r;
    pa_nxt = ws * msel;
    pb = wo * vx_r;
    if (kind_r == ggsg_pkg::REQ_BOUNDARY) begin
      sum = pa_r + HALF_P;
    end else begin
      sum = pa_r + pb + HALF_P;
    end
    sum_sh = sum >>> FRACTION_BITS;
    case (state_r)
      ggsg_pkg::F_FY: nsel = ny_r;
      ggsg_pkg::F_FZ: nsel = nz_r;
      default:        nsel = nx_r;
    endcase
    fp = nsel * phi_r + HALF_F;
    fp_sh = fp >>> FRACTION_BITS;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ggsg_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = (ggsg_pkg::req_kind_t'(in_req_type) == ggsg_pkg::REQ_FINALIZE)
                      ? ggsg_pkg::F_PUSH : ggsg_pkg::F_MUL_A;
        end
      end
      ggsg_pkg::F_MUL_A: state_nxt = ggsg_pkg::F_MUL_B;
      ggsg_pkg::F_MUL_B: state_nxt = ggsg_pkg::F_FX;
      ggsg_pkg::F_FX:    state_nxt = ggsg_pkg::F_FY;
      ggsg_pkg::F_FY:    state_nxt = ggsg_pkg::F_FZ;
      ggsg_pkg::F_FZ:    state_nxt = ggsg_pkg::F_PUSH;
      ggsg_pkg::F_PUSH:  if (!q_full) state_nxt = ggsg_pkg::F_IDLE;
      default:           state_nxt = ggsg_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    front_busy = (state_r != ggsg_pkg::F_IDLE);
    push = (state_r == ggsg_pkg::F_PUSH) && !q_full;
    push_op.kind  = kind_r;
    push_op.own   = own_r;
    push_op.nei   = nei_r;
    push_op.fx    = fx_r;
    push_op.fy    = fy_r;
    push_op.fz    = fz_r;
    push_op.scale = scale_r;
    push_op.vol   = vol_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ggsg_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ggsg_pkg::F_IDLE && accept) begin
      kind_r  <= ggsg_pkg::req_kind_t'(in_req_type);
      own_r   <= in_owner_cell;
      nei_r   <= in_neighbour_cell;
      nx_r    <= in_normal_x;
      ny_r    <= in_normal_y;
      nz_r    <= in_normal_z;
      w_r     <= w_cl;
      vo_r    <= in_value_owner;
      vx_r    <= in_value_other;
      scale_r <= in_cell_scale;
      vol_r   <= in_cell_volume;
    end
    if (state_r == ggsg_pkg::F_MUL_A) pa_r <= pa_nxt;
    if (state_r == ggsg_pkg::F_MUL_B) phi_r <= sum_sh[31:0];
    if (state_r == ggsg_pkg::F_FX) fx_r <= fp_sh[ggsg_pkg::FLUX_W-1:0];
    if (state_r == ggsg_pkg::F_FY) fy_r <= fp_sh[ggsg_pkg::FLUX_W-1:0];
    if (state_r == ggsg_pkg::F_FZ) fz_r <= fp_sh[ggsg_pkg::FLUX_W-1:0];
  end

endmodule

FILE: hw/rtl/ggsg_fifo.sv
// two-entry queue of classified operations between front and back
// depends on ggsg_pkg
module ggsg_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ggsg_pkg::op_t push_op,
  input  logic          pop,
  output ggsg_pkg::op_t head,
  output logic          empty,
  output logic          full
);

  ggsg_pkg::op_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_op;
  end

endmodule

FILE: hw/rtl/ggsg_back.sv
// back end: accumulator store, read-modify-write of faces, finalize divider
// depends on ggsg_pkg
module ggsg_back #(
  parameter int CELL_COUNT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ggsg_pkg::op_t               head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        clearing,
  output logic                        out_strobe,
  output logic [ggsg_pkg::CELL_W-1:0] out_cell_index,
  output logic signed [31:0]          out_grad_x,
  output logic signed [31:0]          out_grad_y,
  output logic signed [31:0]          out_grad_z
);

  localparam int DEPTH = (CELL_COUNT < 1024) ? CELL_COUNT : 1024;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AC = ggsg_pkg::ACC_W;
  localparam int FW = ggsg_pkg::FLUX_W;

  ggsg_pkg::back_state_t state_r, state_nxt;
  ggsg_pkg::op_t op_r;
  logic [3*AC-1:0] mem [DEPTH];
  logic [3*AC-1:0] rd_r, wd;
  logic re, we;
  logic [AW-1:0] ra, wa, clr_cnt_r;
  logic clearing_r;
  logic [1:0] comp_r;
  logic neg_r, zero_r, sat_r;
  logic [47:0] amag_r, amag;
  logic [31:0] bmag_r, bmag;
  logic [63:0] plo_r;
  logic [47:0] phi_part;
  logic [79:0] prod_r;
  logic [30:0] rem_r;
  logic [31:0] dq_r, t;
  logic ge;
  logic [4:0] cnt_r;
  logic signed [AC-1:0] acc_c;
  logic [32:0] lim, mag;
  logic [31:0] res;
  logic signed [31:0] grad_r [3];
  logic chk_zero, chk_sat;

  function automatic logic cell_ok(input logic [ggsg_pkg::CELL_W-1:0] c);
    cell_ok = (32'(c) < 32'(CELL_COUNT));
  endfunction

  function automatic logic [AC-1:0] sat_add(input logic signed [AC-1:0] a,
                                            input logic signed [FW-1:0] f,
                                            input logic sub);
    logic signed [FW:0] s;
    logic signed [FW:0] fe;
    fe = sub ? -f : f;
    s = a + fe;
    if (s > $signed((FW+1)'((64'(1) << (AC-1)) - 64'(1)))) begin
      sat_add = {1'b0, {(AC-1){1'b1}}};
    end else if (s < -$signed((FW+1)'(64'(1) << (AC-1)))) begin
      sat_add = {1'b1, {(AC-1){1'b0}}};
    end else begin
      sat_add = s[AC-1:0];
    end
  endfunction

  assign clearing = clearing_r;

  always_comb begin
    acc_c = rd_r[comp_r*AC +: AC];
    amag = acc_c[AC-1] ? 48'(-acc_c) : 48'(acc_c);
    bmag = op_r.scale[31] ? 32'(-op_r.scale) : 32'(op_r.scale);
    phi_part = amag_r[47:32] * bmag_r;
    chk_zero = (prod_r == 80'd0);
    chk_sat = (prod_r[79:32] >= {17'd0, op_r.vol});
    t = {rem_r, dq_r[31]};
    ge = (t >= {1'b0, op_r.vol});
    lim = neg_r ? 33'h080000000 : 33'h07fffffff;
    mag = {1'b0, dq_r} + {32'd0, ({rem_r, 1'b0} >= {1'b0, op_r.vol})};
    if (zero_r) begin
      mag = 33'd0;
    end else if (sat_r || mag > lim) begin
      mag = lim;
    end
    res = neg_r ? 32'(-mag) : mag[31:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ggsg_pkg::B_IDLE: begin
        if (!clearing_r && !empty) begin
          if (head.kind == ggsg_pkg::REQ_FINALIZE) begin
            state_nxt = cell_ok(head.own) ? ggsg_pkg::B_FRD : ggsg_pkg::B_EMIT;
          end else if (cell_ok(head.own)) begin
            state_nxt = ggsg_pkg::B_ORD;
          end else if (head.kind == ggsg_pkg::REQ_INTERNAL && cell_ok(head.nei)) begin
            state_nxt = ggsg_pkg::B_NRD;
          end
        end
      end
      ggsg_pkg::B_ORD: state_nxt = ggsg_pkg::B_OWR;
      ggsg_pkg::B_OWR: begin
        state_nxt = (op_r.kind == ggsg_pkg::REQ_INTERNAL && cell_ok(op_r.nei))
                    ? ggsg_pkg::B_NRD : ggsg_pkg::B_IDLE;
      end
      ggsg_pkg::B_NRD: state_nxt = ggsg_pkg::B_NWR;
      ggsg_pkg::B_NWR: state_nxt = ggsg_pkg::B_IDLE;
      ggsg_pkg::B_FRD: state_nxt = ggsg_pkg::B_FLD;
      ggsg_pkg::B_FLD: state_nxt = ggsg_pkg::B_MLO;
      ggsg_pkg::B_MLO: state_nxt = ggsg_pkg::B_MHI;
      ggsg_pkg::B_MHI: state_nxt = ggsg_pkg::B_CHK;
      ggsg_pkg::B_CHK: state_nxt = (chk_zero || chk_sat) ? ggsg_pkg::B_RND : ggsg_pkg::B_DIV;
      ggsg_pkg::B_DIV: if (cnt_r == 5'd31) state_nxt = ggsg_pkg::B_RND;
      ggsg_pkg::B_RND: state_nxt = (comp_r == 2'd2) ? ggsg_pkg::B_EMIT : ggsg_pkg::B_MLO;
      ggsg_pkg::B_EMIT: state_nxt = ggsg_pkg::B_IDLE;
      default: state_nxt = ggsg_pkg::B_IDLE;
    endcase
  end

  // outputs: queue pop and store port
  always_comb begin
    pop = (state_r == ggsg_pkg::B_IDLE) && !clearing_r && !empty;
    re = 1'b0;
    ra = op_r.own[AW-1:0];
    we = 1'b0;
    wa = op_r.own[AW-1:0];
    wd = '0;
    case (state_r)
      ggsg_pkg::B_IDLE: begin
        if (clearing_r) begin
          we = 1'b1;
          wa = clr_cnt_r;
        end
      end
      ggsg_pkg::B_ORD: re = 1'b1;
      ggsg_pkg::B_FRD: re = 1'b1;
      ggsg_pkg::B_NRD: begin
        re = 1'b1;
        ra = op_r.nei[AW-1:0];
      end
      ggsg_pkg::B_OWR: begin
        we = 1'b1;
        wd = {sat_add(rd_r[2*AC +: AC], op_r.fz, 1'b0),
              sat_add(rd_r[AC +: AC], op_r.fy, 1'b0),
              sat_add(rd_r[0 +: AC], op_r.fx, 1'b0)};
      end
      ggsg_pkg::B_NWR: begin
        we = 1'b1;
        wa = op_r.nei[AW-1:0];
        wd = {sat_add(rd_r[2*AC +: AC], op_r.fz, 1'b1),
              sat_add(rd_r[AC +: AC], op_r.fy, 1'b1),
              sat_add(rd_r[0 +: AC], op_r.fx, 1'b1)};
      end
      ggsg_pkg::B_FLD: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ggsg_pkg::B_IDLE;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_strobe <= (state_r == ggsg_pkg::B_EMIT);
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= head;
      comp_r <= 2'd0;
      grad_r[0] <= '0;
      grad_r[1] <= '0;
      grad_r[2] <= '0;
    end
    case (state_r)
      ggsg_pkg::B_MLO: begin
        amag_r <= amag;
        bmag_r <= bmag;
        neg_r <= acc_c[AC-1] != op_r.scale[31];
        plo_r <= amag[31:0] * bmag;
      end
      ggsg_pkg::B_MHI: prod_r <= 80'(plo_r) + {phi_part, 32'd0};
      ggsg_pkg::B_CHK: begin
        zero_r <= chk_zero;
        sat_r <= chk_sat;
        rem_r <= prod_r[62:32];
        dq_r <= prod_r[31:0];
        cnt_r <= 5'd0;
      end
      ggsg_pkg::B_DIV: begin
        rem_r <= ge ? 31'(t - {1'b0, op_r.vol}) : t[30:0];
        dq_r <= {dq_r[30:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      ggsg_pkg::B_RND: begin
        grad_r[comp_r] <= res;
        comp_r <= comp_r + 2'd1;
      end
      ggsg_pkg::B_EMIT: begin
        out_cell_index <= op_r.own;
        out_grad_x <= grad_r[0];
        out_grad_y <= grad_r[1];
        out_grad_z <= grad_r[2];
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/green_gauss_scalar_gradient_top.sv
// top level of the green-gauss scalar gradient block
// depends on ggsg_pkg, ggsg_front, ggsg_fifo, ggsg_back and the assertion header
//
// usage: drive the in_ fields and raise start; the beat is taken at an edge
// where start is high and busy is low. face beats (internal, physical
// boundary, processor boundary) add flux to the per-cell accumulators and
// give no result. a finalize beat gives one result beat: out_strobe is high
// for one cycle with out_cell_index and out_grad_x/y/z, and the cell's
// accumulator is cleared.
// the front holds busy from a beat until it pushes it into the queue (for a face
// beat it first forms face value, then x, y and z flux on one shared flux
// multiplier; a full queue stalls the push), so it takes no new beat before
// the last is queued; a two-entry queue lets it run ahead. the back pops each
// face, then reads and writes on one store port, twice for internal faces, and
// runs the three components of a finalize through one 32-step restoring
// divider. after reset a clearing pass zeroes the store (up to 1024 cells),
// one cell per cycle, during which busy is high.
// the receiver cannot stall: results must be taken as they come.
module green_gauss_scalar_gradient_top #(
  parameter int CELL_COUNT    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [9:0]                  in_owner_cell,
  input  logic [9:0]                  in_neighbour_cell,
  input  logic signed [31:0]          in_normal_x,
  input  logic signed [31:0]          in_normal_y,
  input  logic signed [31:0]          in_normal_z,
  input  logic [16:0]                 in_weight,
  input  logic signed [31:0]          in_value_owner,
  input  logic signed [31:0]          in_value_other,
  input  logic signed [31:0]          in_cell_scale,
  input  logic [30:0]                 in_cell_volume,
  output logic                        out_strobe,
  output logic [9:0]                  out_cell_index,
  output logic signed [31:0]          out_grad_x,
  output logic signed [31:0]          out_grad_y,
  output logic signed [31:0]          out_grad_z
);

  logic front_busy, clearing, accept, push, pop, empty, full;
  ggsg_pkg::op_t push_op, head;

  assign busy = front_busy || clearing;
  assign accept = start && !busy;

  ggsg_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept),
    .in_req_type(in_req_type), .in_owner_cell(in_owner_cell),
    .in_neighbour_cell(in_neighbour_cell),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_weight(in_weight), .in_value_owner(in_value_owner),
    .in_value_other(in_value_other), .in_cell_scale(in_cell_scale),
    .in_cell_volume(in_cell_volume), .q_full(full),
    .front_busy(front_busy), .push(push), .push_op(push_op)
  );

  ggsg_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op),
    .pop(pop), .head(head), .empty(empty), .full(full)
  );

  ggsg_back #(.CELL_COUNT(CELL_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
    .clearing(clearing), .out_strobe(out_strobe),
    .out_cell_index(out_cell_index), .out_grad_x(out_grad_x),
    .out_grad_y(out_grad_y), .out_grad_z(out_grad_z)
  );

`include "green_gauss_scalar_gradient_top_assert.svh"

  `GGSG_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held two cycles")
  `GGSG_ASSERT_IMPL(a_clear_busy, clearing, busy, "beat possible during clearing pass")
  `GGSG_ASSERT_IMPL(a_clear_quiet, clearing, !out_strobe, "result during clearing pass")
  `GGSG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "front idle after accepting a beat")

endmodule

FILE: tb/green_gauss_scalar_gradient_top_tb.sv
// self-checking testbench of the green-gauss scalar gradient block
// depends on ggsg_pkg and green_gauss_scalar_gradient_top; holds its own fixed-point predictor
// of the per-cell accumulators and checks every finalize result against it or a given expected result
module green_gauss_scalar_gradient_top_tb;
  import ggsg_pkg::*;

  localparam int NCELLS    = 1024;
  localparam int FRAC      = 16;
  localparam int WDOG_MAX  = 20000;
  localparam longint ONE   = 64'sd1 << FRAC;
  localparam longint HALF  = 64'sd1 << (FRAC - 1);
  localparam longint AMAX  = (64'sd1 << 47) - 1;
  localparam longint AMIN  = -(64'sd1 << 47);

  typedef struct {
    req_kind_t       kind;
    bit [9:0]        own;
    bit [9:0]        nei;
    bit signed [31:0] nx, ny, nz;
    bit [16:0]       w;
    bit signed [31:0] vo, vx, scale;
    bit [30:0]       vol;
  } gg_beat_t;

  typedef struct {
    bit [9:0]  cell_idx;
    bit [31:0] gx, gy, gz;
  } grad_t;

  typedef struct {
    gg_beat_t b;
    bit       typed;
    grad_t    res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_strobe;
  logic [9:0] out_cell_index;
  logic signed [31:0] out_grad_x, out_grad_y, out_grad_z;

  gg_beat_t cur = '{REQ_INTERNAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
  bit       cur_typed = 1'b0;
  grad_t    cur_res;

  longint acc_x[NCELLS], acc_y[NCELLS], acc_z[NCELLS];
  grad_t  grad_q[$];
  int     n_err = 0, n_beats = 0, n_grads = 0, wdog = 0;

  always #10 clk = ~clk;

  green_gauss_scalar_gradient_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(cur.kind), .in_owner_cell(cur.own), .in_neighbour_cell(cur.nei),
    .in_normal_x(cur.nx), .in_normal_y(cur.ny), .in_normal_z(cur.nz),
    .in_weight(cur.w), .in_value_owner(cur.vo), .in_value_other(cur.vx),
    .in_cell_scale(cur.scale), .in_cell_volume(cur.vol),
    .out_strobe(out_strobe), .out_cell_index(out_cell_index),
    .out_grad_x(out_grad_x), .out_grad_y(out_grad_y), .out_grad_z(out_grad_z)
  );

  function automatic longint sat48(longint x);
    if (x > AMAX) return AMAX;
    if (x < AMIN) return AMIN;
    return x;
  endfunction

  function automatic bit [31:0] scaled_grad(longint acc, longint scale, bit [30:0] vol);
    bit neg;
    bit [79:0] a, b, p, q, r, mag, lim;
    neg = (acc < 0) != (scale < 0);
    a = (acc < 0) ? -acc : acc;
    b = (scale < 0) ? -scale : scale;
    if (a == 0 || b == 0) return 32'd0;
    p = a * b;
    lim = neg ? 80'h8000_0000 : 80'h7fff_ffff;
    if (vol == 0) begin
      mag = lim;
    end else begin
      q = p / vol;
      r = p % vol;
      mag = q + ((2 * r >= vol) ? 1 : 0);
      if (mag > lim) mag = lim;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  // updates the accumulators; returns 1 with the gradient on a finalize
  function automatic bit gradient_update(gg_beat_t b, output grad_t g);
    longint w, phi, fx, fy, fz;
    w = (b.w > ONE) ? ONE : longint'(b.w);
    if (b.kind == REQ_FINALIZE) begin
      g.cell_idx = b.own;
      g.gx = scaled_grad(acc_x[b.own], b.scale, b.vol);
      g.gy = scaled_grad(acc_y[b.own], b.scale, b.vol);
      g.gz = scaled_grad(acc_z[b.own], b.scale, b.vol);
      acc_x[b.own] = 0;
      acc_y[b.own] = 0;
      acc_z[b.own] = 0;
      return 1'b1;
    end
    if (b.kind == REQ_BOUNDARY)
      phi = (w * longint'(b.vx) + HALF) >>> FRAC;
    else
      phi = (w * longint'(b.vo) + (ONE - w) * longint'(b.vx) + HALF) >>> FRAC;
    fx = (longint'(b.nx) * phi + HALF) >>> FRAC;
    fy = (longint'(b.ny) * phi + HALF) >>> FRAC;
    fz = (longint'(b.nz) * phi + HALF) >>> FRAC;
    acc_x[b.own] = sat48(acc_x[b.own] + fx);
    acc_y[b.own] = sat48(acc_y[b.own] + fy);
    acc_z[b.own] = sat48(acc_z[b.own] + fz);
    if (b.kind == REQ_INTERNAL) begin
      acc_x[b.nei] = sat48(acc_x[b.nei] - fx);
      acc_y[b.nei] = sat48(acc_y[b.nei] - fy);
      acc_z[b.nei] = sat48(acc_z[b.nei] - fz);
    end
    return 1'b0;
  endfunction

  // beat acceptance, prediction and result check
  always @(posedge clk) begin
    grad_t g, e;
    if (rst_n) begin
      if (start && !busy) begin
        n_beats++;
        if (gradient_update(cur, g)) grad_q.push_back(cur_typed ? cur_res : g);
      end
      if (out_strobe) begin
        n_grads++;
        if (grad_q.size() == 0) begin
          $error("unexpected result beat for cell %0d", out_cell_index);
          n_err++;
        end else begin
          e = grad_q.pop_front();
          if (out_cell_index !== e.cell_idx) begin
            $error("cell_index exp %0d got %0d", e.cell_idx, out_cell_index);
            n_err++;
          end
          if (out_grad_x !== e.gx) begin
            $error("grad_x exp %h got %h", e.gx, out_grad_x);
            n_err++;
          end
          if (out_grad_y !== e.gy) begin
            $error("grad_y exp %h got %h", e.gy, out_grad_y);
            n_err++;
          end
          if (out_grad_z !== e.gz) begin
            $error("grad_z exp %h got %h", e.gz, out_grad_z);
            n_err++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(gg_beat_t b, bit typed, grad_t res, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    cur = b;
    cur_typed = typed;
    cur_res = res;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic bit [31:0] rand_val(int wide_pct);
    if ($urandom_range(99) < wide_pct) return $urandom;
    return $signed($urandom_range(2097151)) - 1048576;
  endfunction

  function automatic gg_beat_t rand_beat(bit [9:0] base);
    gg_beat_t b;
    b.kind  = ($urandom_range(7) == 0) ? REQ_FINALIZE : req_kind_t'($urandom_range(2));
    b.own   = ($urandom_range(9) == 0) ? 10'($urandom) : base + 10'($urandom_range(7));
    b.nei   = ($urandom_range(9) == 0) ? 10'($urandom) : base + 10'($urandom_range(7));
    b.nx    = rand_val(20);
    b.ny    = rand_val(20);
    b.nz    = rand_val(20);
    b.w     = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    b.vo    = rand_val(20);
    b.vx    = rand_val(20);
    b.scale = rand_val(15);
    case ($urandom_range(19))
      0:       b.vol = 31'($urandom_range(1));
      1, 2:    b.vol = 31'($urandom);
      default: b.vol = 31'($urandom_range(1 << 20, 1 << 12));
    endcase
    return b;
  endfunction

  initial begin
    dir_row_t dir[$];
    grad_t    none;
    bit [9:0] base;
    none = '{0, 0, 0, 0};
    // finalize after reset, then full-scale boundary and zero-volume finalize
    dir.push_back('{'{REQ_FINALIZE, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000},
                   1, '{0, 0, 0, 0}});
    dir.push_back('{'{REQ_BOUNDARY, 1, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 17'h1_0000,
                      0, 32'h7fff_ffff, 0, 1}, 0, none});
    dir.push_back('{'{REQ_FINALIZE, 1, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0},
                   1, '{1, 32'h7fff_ffff, 32'h8000_0000, 0}});
    // owner equal to neighbour, weight above one
    dir.push_back('{'{REQ_INTERNAL, 10'h3ff, 10'h3ff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h0003_0000, 17'h1_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 1}, 0, none});
    dir.push_back('{'{REQ_FINALIZE, 10'h3ff, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 31'h7fff_ffff},
                   0, none});
    for (int i = 0; i < 6; i++)
      dir.push_back('{'{REQ_PROCESSOR, 2, 3, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000,
                        17'(i * 13107), 32'h7fff_ffff, 32'h8000_0000, 0, 1}, 0, none});
    dir.push_back('{'{REQ_INTERNAL, 3, 2, 32'h0002_8000, 32'hfffe_8000, 32'h8000_0000,
                      0, 32'h0000_8000, 32'hffff_8000, 0, 1}, 0, none});
    dir.push_back('{'{REQ_BOUNDARY, 2, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      17'h0_8000, 0, 32'h8000_0000, 0, 1}, 0, none});
    dir.push_back('{'{REQ_FINALIZE, 2, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 31'h7fff_ffff},
                   0, none});
    dir.push_back('{'{REQ_FINALIZE, 3, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0001, 1}, 0, none});
    dir.push_back('{'{REQ_FINALIZE, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{4, 0, 0, 0}});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir[i]) send_beat(dir[i].b, dir[i].typed, dir[i].res, 0);

    base = 10'($urandom);
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 245; k++) begin
        if ($urandom_range(39) == 0) base = 10'($urandom);
        send_beat(rand_beat(base), 0, none, (ph == 0) ? 6 : (ph == 1) ? 70 : 0);
      end
      // hold off until every pending gradient has come out
      start = 1'b0;
      while (grad_q.size() != 0) @(negedge clk);
    end

    repeat (300) @(negedge clk);
    $display("covered %0d beats over three idling phases, %0d gradient results checked",
             n_beats, n_grads);
    if (grad_q.size() != 0) begin
      $error("%0d gradient results never arrived", grad_q.size());
      n_err++;
    end
    if (n_err == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ggsg_pkg.sv
hw/rtl/ggsg_front.sv
hw/rtl/ggsg_fifo.sv
hw/rtl/ggsg_back.sv
hw/rtl/green_gauss_scalar_gradient_top.sv
tb/green_gauss_scalar_gradient_top_tb.sv
